// ===== rtl/pcxrle_pkg.sv =====
// ============================================================================
// pcxrle_pkg
// Shared types and constants of the PCX RLE image decoder.
// ============================================================================
`default_nettype none

package pcxrle_pkg;

    localparam int MAX_DIM         = 4096;
    localparam int HEADER_BYTES    = 128;
    localparam int PALETTE_ENTRIES = 256;

    localparam int DIM_W   = 13;   // a side of at most MAX_DIM
    localparam int REM_W   = 25;   // MAX_DIM * MAX_DIM needs 25 bits
    localparam int IDX_W   = 24;
    localparam int RUN_W   = 6;
    localparam int SIDE_W  = 17;
    localparam int HCNT_W  = 7;

    // header bytes 4..11 hold xmin, ymin, xmax, ymax (little endian)
    localparam logic [HCNT_W-1:0] WIN_FIRST = 7'd4;
    localparam logic [HCNT_W-1:0] WIN_LAST  = 7'd11;
    localparam logic [HCNT_W-1:0] HDR_LAST  = 7'(HEADER_BYTES - 1);
    localparam logic [7:0]        ENTRY_LAST = 8'(PALETTE_ENTRIES - 1);
    localparam logic [1:0]        RUN_TAG   = 2'b11;   // byte >= 192

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SIZE,
        PH_DATA,
        PH_PALETTE,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PIXEL    = 2'd0,
        KIND_PALETTE  = 2'd1,
        KIND_SIZE     = 2'd2,
        KIND_SIZE_ERR = 2'd3
    } kind_t;

    // one command: count results; pixel_index steps by one per result
    typedef struct packed {
        kind_t              kind;
        logic [7:0]         pixel_value;
        logic [IDX_W-1:0]   pixel_index;
        logic [RUN_W-1:0]   count;
        logic [7:0]         entry_index;
        logic [5:0]         red;
        logic [5:0]         green;
        logic [5:0]         blue;
        logic [SIDE_W-1:0]  img_width;
        logic [SIDE_W-1:0]  img_height;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

`default_nettype wire

// ===== rtl/pcx_rle_image_decoder_unit.sv =====
// ============================================================================
// pcx_rle_image_decoder_unit
// PCX 8-bit RLE decoder: header, size report, pixels and palette.
// ============================================================================
// One PCX file byte enters per request on the s_ side; set s_tuser on the
// first byte of a file to restart. Bytes 4..11 of the 128-byte header give
// xmin, ymin, xmax, ymax; on header byte 127 one size result goes out
// (kind 2), or a size error (kind 3) when a side exceeds 4096, after which
// bytes are swallowed until the next restart. RLE data follows: a byte of
// 192 or more sets a run of (byte - 192) copies of the next byte, any other
// byte is one pixel; decoding stops after exactly width*height pixels and
// excess run pixels are dropped. The next 768 bytes become 256 palette
// entries with 6-bit components; later bytes are ignored. m_tlast marks the
// last result caused by one input byte.
// Rate: the parser takes one byte per cycle while the command queue is not
// full; it pauses in the size phase after the last header byte while the
// 13x13 pixel-count multiply settles. The emitter puts out one result per
// cycle while m_tready is high. A run byte pair yields up to 63 results;
// the four-entry command queue lets the parser keep taking bytes while a run drains.
// ============================================================================
`default_nettype none

module pcx_rle_image_decoder_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tuser,   // [0] start_file
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // pixel_value, pixel_index, entry_index,
                                        // red, green, blue, img_width, img_height
    output logic [1:0]       m_tuser,   // [1:0] kind
    output logic             m_tlast
);

    logic                   q_push, q_pop;
    pcxrle_pkg::cmd_t       push_cmd, head_cmd, out_cmd;
    pcxrle_pkg::fifo_stat_t q_stat;

    pcxrle_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .start_file (s_tuser),
        .q_stat     (q_stat),
        .push       (q_push),
        .push_cmd   (push_cmd)
    );

    pcxrle_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    pcxrle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_cmd   (out_cmd),
        .out_last  (m_tlast)
    );

    // fields of other kinds are zero in every command
    assign m_tuser = out_cmd.kind;
    assign m_tdata = {4'h0,
                      out_cmd.img_height,
                      out_cmd.img_width,
                      out_cmd.blue,
                      out_cmd.green,
                      out_cmd.red,
                      out_cmd.entry_index,
                      out_cmd.pixel_index,
                      out_cmd.pixel_value};

    // parser never writes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("command queue overflow");

    // emitter never takes from an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("command queue underflow");

    // size and palette results are single results per byte
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != pcxrle_pkg::KIND_PIXEL) |-> m_tlast)
        else $error("non-pixel result without last");

    // no queued command is ever empty
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (push_cmd.count != 6'd0))
        else $error("empty command queued");

endmodule

`default_nettype wire

// ===== rtl/pcxrle_fifo.sv =====
// ============================================================================
// pcxrle_fifo
// Four-entry command queue between the byte parser and the result emitter.
// ============================================================================
`default_nettype none

module pcxrle_fifo (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire pcxrle_pkg::cmd_t      push_cmd,
    input  wire logic                  pop,
    output pcxrle_pkg::cmd_t           head_cmd,
    output pcxrle_pkg::fifo_stat_t     stat
);

    pcxrle_pkg::cmd_t mem_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        cnt_next    = cnt_reg + {2'b0, push} - {2'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == 3'd4);
    assign stat.empty = (cnt_reg == 3'd0);

endmodule

`default_nettype wire

// ===== rtl/pcxrle_front.sv =====
// ============================================================================
// pcxrle_front
// Byte parser: header capture, size check, RLE classification, palette.
// ============================================================================
`default_nettype none

module pcxrle_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            in_byte,
    input  wire logic                  start_file,
    input  wire pcxrle_pkg::fifo_stat_t q_stat,
    output logic                       push,
    output pcxrle_pkg::cmd_t           push_cmd
);

    pcxrle_pkg::phase_t phase_reg, phase_next, cur_phase;

    logic [pcxrle_pkg::HCNT_W-1:0] hdr_cnt_reg, hdr_cnt_next, hdr_cnt_eff;
    logic [15:0] win_reg [4];
    logic [pcxrle_pkg::DIM_W-1:0]  w_reg, h_reg;
    logic                          empty_reg, empty_next;
    logic [pcxrle_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [pcxrle_pkg::IDX_W-1:0]  done_reg, done_next;
    logic [pcxrle_pkg::RUN_W-1:0]  pend_reg, pend_next;
    logic                          run_flag_reg, run_flag_next;
    logic [1:0]                    sub_reg, sub_next;
    logic [7:0]                    entry_reg, entry_next;
    logic [5:0]                    red_reg, red_next;
    logic [5:0]                    green_reg, green_next;

    logic                              accept;
    logic [pcxrle_pkg::SIDE_W-1:0]     side_w, side_h;
    logic                              size_bad;
    logic [2*pcxrle_pkg::DIM_W-1:0]    area;
    logic [pcxrle_pkg::RUN_W-1:0]      run_n;
    logic [pcxrle_pkg::HCNT_W-1:0]     win_off;
    logic [1:0]                        win_idx;
    logic                              win_cap;

    assign in_ready  = (phase_reg != pcxrle_pkg::PH_SIZE) && !q_stat.full;
    assign accept    = in_valid && in_ready;
    assign cur_phase = start_file ? pcxrle_pkg::PH_HEADER : phase_reg;
    assign hdr_cnt_eff = start_file ? '0 : hdr_cnt_reg;

    // header window decode
    assign win_off = hdr_cnt_eff - pcxrle_pkg::WIN_FIRST;
    assign win_idx = win_off[2:1];
    assign win_cap = (hdr_cnt_eff >= pcxrle_pkg::WIN_FIRST) &&
                     (hdr_cnt_eff <= pcxrle_pkg::WIN_LAST);

    assign side_w = {1'b0, win_reg[2]} - {1'b0, win_reg[0]} + 17'd1;
    assign side_h = {1'b0, win_reg[3]} - {1'b0, win_reg[1]} + 17'd1;
    assign size_bad = (side_w > 17'(pcxrle_pkg::MAX_DIM)) ||
                      (side_h > 17'(pcxrle_pkg::MAX_DIM));

    assign area  = w_reg * h_reg;
    assign run_n = (rem_reg < {{(pcxrle_pkg::REM_W-pcxrle_pkg::RUN_W){1'b0}}, pend_reg})
                   ? rem_reg[pcxrle_pkg::RUN_W-1:0] : pend_reg;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (phase_reg == pcxrle_pkg::PH_SIZE)
        begin
            phase_next = empty_reg ? pcxrle_pkg::PH_PALETTE : pcxrle_pkg::PH_DATA;
        end
        else if (accept)
        begin
            case (cur_phase)
                pcxrle_pkg::PH_HEADER:
                begin
                    if (hdr_cnt_eff == pcxrle_pkg::HDR_LAST)
                        phase_next = size_bad ? pcxrle_pkg::PH_DONE : pcxrle_pkg::PH_SIZE;
                    else
                        phase_next = pcxrle_pkg::PH_HEADER;
                end
                pcxrle_pkg::PH_DATA:
                begin
                    if (rem_next == '0)
                        phase_next = pcxrle_pkg::PH_PALETTE;
                end
                pcxrle_pkg::PH_PALETTE:
                begin
                    if (sub_reg == 2'd2 && entry_reg == pcxrle_pkg::ENTRY_LAST)
                        phase_next = pcxrle_pkg::PH_DONE;
                end
                default:
                begin
                    phase_next = cur_phase;
                end
            endcase
        end
    end

    // state datapath
    always_comb
    begin
        hdr_cnt_next  = hdr_cnt_reg;
        empty_next    = empty_reg;
        rem_next      = rem_reg;
        done_next     = done_reg;
        pend_next     = pend_reg;
        run_flag_next = run_flag_reg;
        sub_next      = sub_reg;
        entry_next    = entry_reg;
        red_next      = red_reg;
        green_next    = green_reg;
        if (phase_reg == pcxrle_pkg::PH_SIZE)
        begin
            rem_next      = area[pcxrle_pkg::REM_W-1:0];
            done_next     = '0;
            run_flag_next = 1'b0;
            pend_next     = '0;
            sub_next      = '0;
            entry_next    = '0;
        end
        else if (accept)
        begin
            case (cur_phase)
                pcxrle_pkg::PH_HEADER:
                begin
                    hdr_cnt_next  = hdr_cnt_eff + 7'd1;
                    empty_next    = (side_w == '0) || (side_h == '0);
                    run_flag_next = 1'b0;
                end
                pcxrle_pkg::PH_DATA:
                begin
                    if (run_flag_reg)
                    begin
                        rem_next      = rem_reg - {{(pcxrle_pkg::REM_W-pcxrle_pkg::RUN_W){1'b0}}, run_n};
                        done_next     = done_reg + {{(pcxrle_pkg::IDX_W-pcxrle_pkg::RUN_W){1'b0}}, run_n};
                        run_flag_next = 1'b0;
                        pend_next     = '0;
                    end
                    else if (in_byte[7:6] == pcxrle_pkg::RUN_TAG)
                    begin
                        run_flag_next = 1'b1;
                        pend_next     = in_byte[5:0];
                    end
                    else
                    begin
                        rem_next  = rem_reg - 25'd1;
                        done_next = done_reg + 24'd1;
                    end
                    sub_next   = '0;
                    entry_next = '0;
                end
                pcxrle_pkg::PH_PALETTE:
                begin
                    case (sub_reg)
                        2'd0:    red_next   = in_byte[7:2];
                        2'd1:    green_next = in_byte[7:2];
                        default: entry_next = entry_reg + 8'd1;
                    endcase
                    sub_next = (sub_reg == 2'd2) ? 2'd0 : sub_reg + 2'd1;
                end
                default:
                begin
                    hdr_cnt_next = hdr_cnt_reg;
                end
            endcase
        end
    end

    // command out
    always_comb
    begin
        push     = 1'b0;
        push_cmd = '0;
        if (accept)
        begin
            case (cur_phase)
                pcxrle_pkg::PH_HEADER:
                begin
                    if (hdr_cnt_eff == pcxrle_pkg::HDR_LAST)
                    begin
                        push               = 1'b1;
                        push_cmd.kind      = size_bad ? pcxrle_pkg::KIND_SIZE_ERR
                                                      : pcxrle_pkg::KIND_SIZE;
                        push_cmd.count     = 6'd1;
                        push_cmd.img_width = side_w;
                        push_cmd.img_height = side_h;
                    end
                end
                pcxrle_pkg::PH_DATA:
                begin
                    push_cmd.kind        = pcxrle_pkg::KIND_PIXEL;
                    push_cmd.pixel_value = in_byte;
                    push_cmd.pixel_index = done_reg;
                    if (run_flag_reg)
                    begin
                        push           = (run_n != '0);
                        push_cmd.count = run_n;
                    end
                    else
                    begin
                        push           = (in_byte[7:6] != pcxrle_pkg::RUN_TAG);
                        push_cmd.count = 6'd1;
                    end
                end
                pcxrle_pkg::PH_PALETTE:
                begin
                    if (sub_reg == 2'd2)
                    begin
                        push                 = 1'b1;
                        push_cmd.kind        = pcxrle_pkg::KIND_PALETTE;
                        push_cmd.count       = 6'd1;
                        push_cmd.entry_index = entry_reg;
                        push_cmd.red         = red_reg;
                        push_cmd.green       = green_reg;
                        push_cmd.blue        = in_byte[7:2];
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= pcxrle_pkg::PH_HEADER;
            hdr_cnt_reg  <= '0;
            empty_reg    <= 1'b0;
            rem_reg      <= '0;
            done_reg     <= '0;
            pend_reg     <= '0;
            run_flag_reg <= 1'b0;
            sub_reg      <= '0;
            entry_reg    <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            empty_reg    <= empty_next;
            rem_reg      <= rem_next;
            done_reg     <= done_next;
            pend_reg     <= pend_next;
            run_flag_reg <= run_flag_next;
            sub_reg      <= sub_next;
            entry_reg    <= entry_next;
        end
    end

    // payload: header words, sides, palette components
    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        if (accept && cur_phase == pcxrle_pkg::PH_HEADER)
        begin
            if (win_cap)
            begin
                if (win_off[0])
                    win_reg[win_idx][15:8] <= in_byte;
                else
                    win_reg[win_idx] <= {8'h00, in_byte};
            end
            if (hdr_cnt_eff == pcxrle_pkg::HDR_LAST)
            begin
                w_reg <= side_w[pcxrle_pkg::DIM_W-1:0];
                h_reg <= side_h[pcxrle_pkg::DIM_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pcxrle_back.sv =====
// ============================================================================
// pcxrle_back
// Result emitter: expands queued commands into results, one per cycle while out_ready is high.
// ============================================================================
`default_nettype none

module pcxrle_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pcxrle_pkg::cmd_t      head_cmd,
    input  wire pcxrle_pkg::fifo_stat_t q_stat,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output pcxrle_pkg::cmd_t           out_cmd,
    output logic                       out_last
);

    pcxrle_pkg::cmd_t               cur_reg;
    logic                           valid_reg, valid_next;
    logic [pcxrle_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [pcxrle_pkg::RUN_W-1:0]   left_reg, left_next;
    logic                           fire, finish;

    assign fire   = valid_reg && out_ready;
    assign finish = fire && (left_reg == 6'd1);
    assign pop    = !q_stat.empty && (!valid_reg || finish);

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        left_next  = left_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            idx_next   = head_cmd.pixel_index;
            left_next  = head_cmd.count;
        end
        else if (finish)
        begin
            valid_next = 1'b0;
        end
        else if (fire)
        begin
            idx_next  = idx_reg + 24'd1;
            left_next = left_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            left_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (pop)
        begin
            cur_reg <= head_cmd;
        end
    end

    always_comb
    begin
        out_cmd             = cur_reg;
        out_cmd.pixel_index = idx_reg;
        out_cmd.count       = left_reg;
    end

    assign out_valid = valid_reg;
    assign out_last  = (left_reg == 6'd1);

endmodule

`default_nettype wire
